// ===== rtl/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types and constants shared by the button debounce and press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd3;

    // counter widths and saturation limits
    localparam int unsigned TSC_W = 8;
    localparam int unsigned HOLD_W = 17;
    localparam int unsigned LPT_W = 16;
    localparam logic [TSC_W-1:0] TSC_MAX = '1;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    // register reset values
    localparam logic RST_ACTIVE_HIGH = 1'b1;
    localparam logic RST_TOGGLE_MODE = 1'b0;
    localparam logic [TSC_W-1:0] RST_DEBOUNCE = 8'd50;
    localparam logic [LPT_W-1:0] RST_LONG_PRESS = 16'd1000;

    typedef struct packed {
        logic             active_high;
        logic             toggle_mode;
        logic [TSC_W-1:0] debounce_ticks;
        logic [LPT_W-1:0] long_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic              debounced_pressed;
        logic              toggle_on;
        logic [TSC_W-1:0]  ticks_since_change;
        logic [HOLD_W-1:0] hold_ticks;
        logic              hold_active;
    } t_state;

    typedef struct packed {
        logic button_out;
        logic press_event;
        logic release_event;
        logic short_press;
        logic long_press;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/bdpc_in_if.sv =====
// ----------------------------------------------------------------------------
// bdpc_in_if
// Sample channel: one raw pin level per tick, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdpc_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdpc_out_if.sv =====
// ----------------------------------------------------------------------------
// bdpc_out_if
// Result channel: debounced level and event pulses, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdpc_out_if;
    logic valid;
    logic ready;
    logic button_out;
    logic press_event;
    logic release_event;
    logic short_press;
    logic long_press;

    modport source (
        output valid, output button_out, output press_event, output release_event,
        output short_press, output long_press, input ready
    );
    modport sink (
        input valid, input button_out, input press_event, input release_event,
        input short_press, input long_press, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/bdpc_core.sv =====
// ----------------------------------------------------------------------------
// bdpc_core
// Next-state and result logic for one tick of the debouncer and classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_core (
    input  wire logic              i_pin_level,
    input  wire bdpc_pkg::t_cfg    i_cfg,
    input  wire bdpc_pkg::t_state  i_state,
    output bdpc_pkg::t_state       o_state,
    output bdpc_pkg::t_result      o_result
);
    import bdpc_pkg::*;

    logic              cur;
    logic              press_mode;
    logic              change;
    logic              held;
    logic [TSC_W-1:0]  tsc;
    logic [HOLD_W-1:0] ht;
    logic [HOLD_W-1:0] lpt_ext;

    // tick update, long press test, then accepted level change
    always_comb begin
        cur        = i_cfg.active_high ? i_pin_level : ~i_pin_level;
        press_mode = ~i_cfg.toggle_mode;
        lpt_ext    = {1'b0, i_cfg.long_press_ticks};
        o_result   = '0;

        // saturating counters
        tsc  = (i_state.ticks_since_change < TSC_MAX) ?
               i_state.ticks_since_change + TSC_W'(1) : i_state.ticks_since_change;
        held = i_state.hold_active & press_mode;
        ht   = (held && i_state.hold_ticks < HOLD_MAX) ?
               i_state.hold_ticks + HOLD_W'(1) : i_state.hold_ticks;

        // long press fires once when the hold passes the limit
        if (held && ht > lpt_ext) begin
            o_result.long_press = 1'b1;
            held = 1'b0;
        end

        o_state                   = i_state;
        o_state.ticks_since_change = tsc;
        o_state.hold_ticks        = ht;

        change = (cur != i_state.debounced_pressed) && (tsc >= i_cfg.debounce_ticks);
        if (change) begin
            o_state.ticks_since_change = '0;
            o_state.debounced_pressed  = cur;
            if (cur) begin
                if (press_mode) begin
                    o_result.press_event = 1'b1;
                    held                 = 1'b1;
                    o_state.hold_ticks   = '0;
                end else begin
                    o_state.toggle_on = ~i_state.toggle_on;
                end
            end else begin
                if (press_mode) begin
                    o_result.release_event = 1'b1;
                    o_result.short_press   = held && (ht < lpt_ext);
                end
                held = 1'b0;
            end
        end
        o_state.hold_active = held;

        o_result.button_out = press_mode ? o_state.debounced_pressed : o_state.toggle_on;
    end

endmodule

`default_nettype wire

// ===== rtl/button_debounce_press_classifier_top.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top
// Debounces a sampled button pin and classifies presses as short or long,
// or flips a toggle state on each accepted press.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                    handshake
//  i_in      sink       pin_level                                  valid/ready
//  o_out     source     button_out, press/release, short/long      valid/ready
//  i_cfg_*   write      register index and data                    write enable
//
//  state and result registers update on the same edge the sample is taken, so
//  a new sample is taken every cycle while the result register is not stalled.
//  a sample is taken whenever the result register is empty or being emptied.
//  a stalled result holds; reset returns registers and state to reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bdpc_in_if.sink                             i_in,
    bdpc_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bdpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bdpc_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    in_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_high      <= RST_ACTIVE_HIGH;
            r_cfg.toggle_mode      <= RST_TOGGLE_MODE;
            r_cfg.debounce_ticks   <= RST_DEBOUNCE;
            r_cfg.long_press_ticks <= RST_LONG_PRESS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_HIGH: r_cfg.active_high      <= i_cfg_data[0];
                CFG_TOGGLE_MODE: r_cfg.toggle_mode      <= i_cfg_data[0];
                CFG_DEBOUNCE:    r_cfg.debounce_ticks   <= i_cfg_data[TSC_W-1:0];
                CFG_LONG_PRESS:  r_cfg.long_press_ticks <= i_cfg_data[LPT_W-1:0];
                default: ;
            endcase
        end
    end

    // input handshake
    assign i_in.ready = ~r_out_valid | o_out.ready;
    assign in_take    = i_in.valid & i_in.ready;

    // per-tick logic
    bdpc_core u_core (
        .i_pin_level (i_in.pin_level),
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.button_out    = r_result.button_out;
    assign o_out.press_event   = r_result.press_event;
    assign o_out.release_event = r_result.release_event;
    assign o_out.short_press   = r_result.short_press;
    assign o_out.long_press    = r_result.long_press;

endmodule

`default_nettype wire

// ===== tb/button_debounce_press_classifier_top_test.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top_test
// Drives pin samples through the debouncer with random idling on both sides
// and checks every result against a tick-level model of the debounce lockout,
// short/long press classification and toggle behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdpc_pkg::*;

    // directed stimulus rows: a tick or a register write
    typedef enum logic {ROW_TICK, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  pin;
        logic                  known;
        t_result               want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bdpc_in_if  tick_if ();
    bdpc_out_if res_if ();

    button_debounce_press_classifier_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_if),
        .o_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // model copy of registers and state
    t_cfg    btn_cfg;
    t_state  btn_state;
    t_result tick_results_due[$];

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    logic        pin_now = 1'b0;
    int unsigned run_left = 0;

    // gap length: mostly none or short, a few long
    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one tick of the debouncer and press classifier
    function automatic t_result classify_tick(input logic pin);
        t_result r;
        logic    pressed_now;
        logic    momentary;
        r = '0;
        momentary = !btn_cfg.toggle_mode;
        pressed_now = btn_cfg.active_high ? pin : !pin;

        if (btn_state.ticks_since_change != TSC_MAX)
            btn_state.ticks_since_change++;
        if (!momentary)
            btn_state.hold_active = 1'b0;
        if (btn_state.hold_active && btn_state.hold_ticks != HOLD_MAX)
            btn_state.hold_ticks++;

        // long test comes before the release test
        if (btn_state.hold_active && btn_state.hold_ticks > btn_cfg.long_press_ticks) begin
            r.long_press = 1'b1;
            btn_state.hold_active = 1'b0;
        end

        if (pressed_now != btn_state.debounced_pressed &&
            btn_state.ticks_since_change >= btn_cfg.debounce_ticks) begin
            btn_state.ticks_since_change = '0;
            btn_state.debounced_pressed = pressed_now;
            if (pressed_now) begin
                if (momentary) begin
                    r.press_event = 1'b1;
                    btn_state.hold_active = 1'b1;
                    btn_state.hold_ticks = '0;
                end else begin
                    btn_state.toggle_on = !btn_state.toggle_on;
                end
            end else begin
                if (momentary) begin
                    r.release_event = 1'b1;
                    if (btn_state.hold_active &&
                        btn_state.hold_ticks < btn_cfg.long_press_ticks)
                        r.short_press = 1'b1;
                end
                btn_state.hold_active = 1'b0;
            end
        end

        r.button_out = momentary ? btn_state.debounced_pressed : btn_state.toggle_on;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        if (mismatches < 10)
            $display("%t: %s", $realtime, msg);
        mismatches++;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want)
            note_failure($sformatf("%s expected %b got %b", name, want, got));
    endfunction

    // compare one result transaction against the oldest pending tick
    function automatic void compare_result(input t_result got);
        t_result want;
        if (tick_results_due.size() == 0) begin
            note_failure($sformatf("result %b with no tick pending", got));
            return;
        end
        want = tick_results_due.pop_front();
        check_field("button_out", want.button_out, got.button_out);
        check_field("press_event", want.press_event, got.press_event);
        check_field("release_event", want.release_event, got.release_event);
        check_field("short_press", want.short_press, got.short_press);
        check_field("long_press", want.long_press, got.long_press);
    endfunction

    // pin level generator: held levels around the lockout and limit, with bounce
    function automatic logic next_pin(input int unsigned deb, input int unsigned cap);
        int unsigned r;
        if (run_left == 0) begin
            pin_now = !pin_now;
            r = $urandom_range(0, 99);
            if (r < 25)
                run_left = $urandom_range(1, 3);
            else if (r < 60)
                run_left = deb + $urandom_range(1, 4);
            else
                run_left = deb + $urandom_range(0, cap + 4);
        end
        run_left--;
        if ($urandom_range(0, 19) == 0)
            return 1'($urandom_range(0, 1));
        return pin_now;
    endfunction

    function automatic t_row known_tick(input logic pin, input t_result want);
        return '{kind: ROW_TICK, reg_idx: '0, reg_data: '0, pin: pin, known: 1'b1, want: want};
    endfunction

    function automatic t_row free_tick(input logic pin);
        return '{kind: ROW_TICK, reg_idx: '0, reg_data: '0, pin: pin, known: 1'b0, want: '0};
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        return '{kind: ROW_REG, reg_idx: idx, reg_data: data, pin: 1'b0, known: 1'b0, want: '0};
    endfunction

    // offer one tick, wait for the transaction, record what it must produce
    task automatic offer_tick(input logic pin, input logic known, input t_result want);
        int unsigned gap;
        t_result     model;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = pick_gap(send_burst);
        if (gap != 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.pin_level <= pin;
        do @(posedge i_clk); while (!tick_if.ready);
        model = classify_tick(pin);
        tick_results_due.push_back(known ? want : model);
    endtask

    // stop offering and wait until every pending result has come out
    task automatic settle();
        tick_if.valid <= 1'b0;
        while (tick_results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ACTIVE_HIGH: btn_cfg.active_high = data[0];
            CFG_TOGGLE_MODE: btn_cfg.toggle_mode = data[0];
            CFG_DEBOUNCE:    btn_cfg.debounce_ticks = data[TSC_W-1:0];
            CFG_LONG_PRESS:  btn_cfg.long_press_ticks = data[LPT_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one configuration, then a stream of press-like pin sequences
    task automatic run_phase(input logic ah, input logic tg, input logic [TSC_W-1:0] deb,
                             input logic [LPT_W-1:0] lim, input int unsigned count);
        int unsigned cap;
        settle();
        write_reg(CFG_ACTIVE_HIGH, CFG_DATA_W'(ah));
        write_reg(CFG_TOGGLE_MODE, CFG_DATA_W'(tg));
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
        write_reg(CFG_LONG_PRESS, CFG_DATA_W'(lim));
        cap = (lim > 40) ? 40 : lim;
        repeat (count) offer_tick(next_pin(deb, cap), 1'b0, '0);
    endtask

    // result side: random stalls, one long hold-off
    initial begin
        int unsigned stall_left;
        int unsigned cycle_cnt;
        bit          long_hold_done;
        stall_left = 0;
        cycle_cnt = 0;
        long_hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                compare_result('{res_if.button_out, res_if.press_event, res_if.release_event,
                                 res_if.short_press, res_if.long_press});
                results_seen++;
            end
            cycle_cnt++;
            if (cycle_cnt % 64 == 0 && $urandom_range(0, 2) == 0)
                recv_burst = !recv_burst;
            if (stall_left != 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1'b1;
                stall_left = 119;
                res_if.ready <= 1'b0;
            end else begin
                stall_left = pick_gap(recv_burst);
                if (stall_left == 0) begin
                    res_if.ready <= 1'b1;
                end else begin
                    res_if.ready <= 1'b0;
                    stall_left--;
                end
            end
        end
    end

    // stimulus and final verdict
    initial begin
        t_row        rows[$];
        int unsigned lim_pick;
        int unsigned deb_pick;
        logic [LPT_W-1:0] lim;
        logic [TSC_W-1:0] deb;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        tick_if.valid <= 1'b0;
        tick_if.pin_level <= 1'b0;
        btn_cfg = '{RST_ACTIVE_HIGH, RST_TOGGLE_MODE, RST_DEBOUNCE, RST_LONG_PRESS};
        btn_state = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // result fields in order: button_out, press, release, short, long
        rows.push_back(known_tick(1'b1, 5'b00000));    // lockout right after reset
        rows.push_back(reg_row(CFG_DEBOUNCE, 16'd0));
        rows.push_back(reg_row(CFG_LONG_PRESS, 16'd2));
        rows.push_back(known_tick(1'b1, 5'b11000));    // zero debounce press
        rows.push_back(known_tick(1'b0, 5'b00110));    // short press
        rows.push_back(known_tick(1'b1, 5'b11000));
        rows.push_back(known_tick(1'b1, 5'b10000));
        rows.push_back(known_tick(1'b1, 5'b10000));
        rows.push_back(known_tick(1'b0, 5'b00101));    // long fires on release tick
        rows.push_back(known_tick(1'b1, 5'b11000));
        rows.push_back(known_tick(1'b1, 5'b10000));
        rows.push_back(known_tick(1'b0, 5'b00100));    // hold equal to limit
        rows.push_back(reg_row(CFG_LONG_PRESS, 16'd0));
        rows.push_back(known_tick(1'b1, 5'b11000));
        rows.push_back(known_tick(1'b1, 5'b10001));    // zero limit, long next tick
        rows.push_back(known_tick(1'b0, 5'b00100));
        rows.push_back(known_tick(1'b1, 5'b11000));
        rows.push_back(known_tick(1'b0, 5'b00101));
        rows.push_back(reg_row(CFG_ACTIVE_HIGH, 16'd0));
        rows.push_back(known_tick(1'b1, 5'b00000));    // active low polarity
        rows.push_back(known_tick(1'b0, 5'b11000));
        rows.push_back(reg_row(CFG_TOGGLE_MODE, 16'd1));   // switch while held
        rows.push_back(free_tick(1'b0));
        rows.push_back(free_tick(1'b1));
        rows.push_back(free_tick(1'b0));
        rows.push_back(free_tick(1'b1));
        rows.push_back(free_tick(1'b0));
        rows.push_back(reg_row(CFG_TOGGLE_MODE, 16'd0));
        rows.push_back(free_tick(1'b0));
        rows.push_back(free_tick(1'b1));
        rows.push_back(reg_row(CFG_ACTIVE_HIGH, 16'd1));
        rows.push_back(reg_row(CFG_DEBOUNCE, 16'd2));
        rows.push_back(reg_row(CFG_LONG_PRESS, 16'd1000));
        rows.push_back(free_tick(1'b1));               // blocked by lockout
        rows.push_back(free_tick(1'b1));
        rows.push_back(free_tick(1'b0));

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_REG) begin
                settle();
                write_reg(rows[k].reg_idx, rows[k].reg_data);
            end else begin
                offer_tick(rows[k].pin, rows[k].known, rows[k].want);
            end
        end

        // extremes first, then random settings
        run_phase(1'b1, 1'b0, 8'd0, 16'd0, 70);
        run_phase(1'b0, 1'b0, 8'd255, 16'd65535, 560);
        run_phase(1'b1, 1'b1, 8'd2, 16'd5, 70);
        repeat (10) begin
            deb_pick = $urandom_range(0, 99);
            lim_pick = $urandom_range(0, 99);
            deb = (deb_pick < 20) ? 8'd0 : TSC_W'($urandom_range(1, 6));
            if (lim_pick < 15)
                lim = '0;
            else if (lim_pick < 25)
                lim = LPT_W'($urandom_range(0, 65535));
            else
                lim = LPT_W'($urandom_range(1, 25));
            run_phase(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0), deb, lim, 75);
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/bdpc_pkg.sv
rtl/bdpc_in_if.sv
rtl/bdpc_out_if.sv
rtl/bdpc_core.sv
rtl/button_debounce_press_classifier_top.sv
tb/button_debounce_press_classifier_top_test.sv
